// File: rtl/joystick_axis_calibrate_scale_unit_defines.svh
// Assertion macros for the joystick axis calibrate and scale unit.
// Included by the top-level RTL file, which carries the concurrent assertions.
`ifndef JOYSTICK_AXIS_CALIBRATE_SCALE_UNIT_DEFINES_SVH
`define JOYSTICK_AXIS_CALIBRATE_SCALE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JACS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JACS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/jacs_pkg.sv
// Shared constants for the joystick axis calibrate and scale unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package jacs_pkg;

    // Default parameter values.
    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int CENTRE_SAMPLES_DEF = 100;

    // Centre value after reset, before masking to the sample width.
    localparam int CENTRE_RESET = 2000;

    // Fixed field widths.
    localparam int VEL_W  = 12;
    localparam int GAIN_W = 11;
    localparam int DZ_W   = 11;

    localparam logic [GAIN_W-1:0] GAIN_FAST = 11'd1600;
    localparam logic [GAIN_W-1:0] GAIN_SLOW = 11'd800;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ENABLE       = 3'd5;

    localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 11'd100;

endpackage

// File: rtl/jacs_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies; instantiated once per axis by the top level.
`timescale 1ns / 1ps

module jacs_serial_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   n_trial;
    logic             n_ge;
    logic [DVS_W:0]   n_diff;
    logic [DVS_W-1:0] n_rem;

    // The dividend shifts out of the top of r_quo while quotient bits enter at the bottom.
    always_comb begin
        n_trial = {r_rem, r_quo[DVD_W-1]};
        n_ge    = (n_trial >= {1'b0, r_dvs});
        n_diff  = n_trial - {1'b0, r_dvs};
        n_rem   = n_ge ? n_diff[DVS_W-1:0] : n_trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DVD_W-2:0], n_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: rtl/joystick_axis_calibrate_scale_unit.sv
// Joystick axis calibrate and scale unit: learns stick center and limits, maps samples to velocity.
// Uses jacs_pkg, jacs_serial_div and the assertion macro header.
// A request passes through ST_PREP, the serial divider (ST_DIV) and ST_OUT before its result is registered.
// A new request is taken only in ST_IDLE, after the last one has left ST_OUT; a result may wait.
// Reset (synchronous, active low) restores configuration, limits, centers and the sample count.
`timescale 1ns / 1ps
`include "joystick_axis_calibrate_scale_unit_defines.svh"

module joystick_axis_calibrate_scale_unit #(
    parameter int SAMPLE_BITS    = jacs_pkg::SAMPLE_BITS_DEF,
    parameter int CENTRE_SAMPLES = jacs_pkg::CENTRE_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [jacs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jacs_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // Sample request channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [SAMPLE_BITS-1:0]              i_x_sample,
    input  logic [SAMPLE_BITS-1:0]              i_y_sample,

    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [jacs_pkg::VEL_W-1:0]   o_x_velocity,
    output logic signed [jacs_pkg::VEL_W-1:0]   o_y_velocity,
    output logic                                o_centre_learning
);

    import jacs_pkg::*;

    // The divider runs over the full gain * displacement product so that the
    // quotient can be saturated at the gain afterwards.
    localparam int DVD_W = SAMPLE_BITS + GAIN_W;
    localparam int CS_W  = $clog2(CENTRE_SAMPLES + 1);
    localparam int DVS_W = (SAMPLE_BITS > CS_W) ? SAMPLE_BITS : CS_W;
    localparam int CNT_W = $clog2(CENTRE_SAMPLES + 2);

    localparam logic [SAMPLE_BITS-1:0] MID_SCALE  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] CENTRE_RST =
        SAMPLE_BITS'(CENTRE_RESET % (1 << SAMPLE_BITS));
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CENTRE_SAMPLES);

    typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_DIV, ST_OUT} t_state;

    // Per-axis values taken at request time: displacement from the center,
    // the span on that side of the center, and whether the stick is on the low side.
    typedef struct packed {
        logic                          neg;
        logic [SAMPLE_BITS-1:0]        d;
        logic signed [SAMPLE_BITS:0]   span;
    } t_axis_prep;

    // Configuration registers.
    logic              r_calibrate_mode;
    logic              r_fast_mode;
    logic [DZ_W-1:0]   r_dead_zone;
    logic              r_invert_x;
    logic              r_invert_y;
    logic              r_y_enable;

    // Learned geometry.
    logic [CNT_W-1:0]       r_sample_count;
    logic [SAMPLE_BITS-1:0] r_x_low_limit;
    logic [SAMPLE_BITS-1:0] r_x_high_limit;
    logic [SAMPLE_BITS-1:0] r_y_low_limit;
    logic [SAMPLE_BITS-1:0] r_y_high_limit;
    logic [SAMPLE_BITS-1:0] r_x_centre;
    logic [SAMPLE_BITS-1:0] r_y_centre;

    // Request in flight.
    t_state                 r_state;
    logic [SAMPLE_BITS-1:0] r_x_smp;
    logic [SAMPLE_BITS-1:0] r_y_smp;
    t_axis_prep             r_x_prep;
    t_axis_prep             r_y_prep;

    // Output register.
    logic                     r_out_valid;
    logic signed [VEL_W-1:0]  r_x_vel;
    logic signed [VEL_W-1:0]  r_y_vel;
    logic                     r_learning;

    logic [GAIN_W-1:0] gain;
    logic              accept;
    logic              out_free;
    logic              div_start;
    logic [DVD_W-1:0]  x_dividend;
    logic [DVD_W-1:0]  y_dividend;
    logic [DVS_W-1:0]  x_divisor;
    logic [DVS_W-1:0]  y_divisor;
    logic [DVD_W-1:0]  x_quo;
    logic [DVD_W-1:0]  y_quo;
    logic              x_done;
    logic              y_done;

    logic [CNT_W-1:0]        n_sample_count;
    logic                    n_learning;
    logic signed [VEL_W-1:0] n_x_vel;
    logic signed [VEL_W-1:0] n_y_vel;

    // A sample equal to the center counts as the low side, as does anything below it.
    function automatic t_axis_prep prep_axis(
        input logic [SAMPLE_BITS-1:0] s,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi,
        input logic [SAMPLE_BITS-1:0] c
    );
        t_axis_prep p;
        if (s > c) begin
            p.neg  = 1'b0;
            p.d    = s - c;
            p.span = signed'({1'b0, hi}) - signed'({1'b0, c});
        end else begin
            p.neg  = 1'b1;
            p.d    = c - s;
            p.span = signed'({1'b0, c}) - signed'({1'b0, lo});
        end
        return p;
    endfunction

    // Saturate the quotient at the gain, apply the dead zone, then the direction.
    // A span that is zero or negative forces the axis to zero.
    function automatic logic signed [VEL_W-1:0] map_vel(
        input logic [DVD_W-1:0]  q,
        input t_axis_prep        p,
        input logic              inv,
        input logic [GAIN_W-1:0] g,
        input logic [DZ_W-1:0]   dz
    );
        logic [GAIN_W-1:0] mag;
        logic [VEL_W-1:0]  pos;
        logic              span_bad;
        logic signed [VEL_W-1:0] res;
        span_bad = p.span[SAMPLE_BITS] || (p.span == '0);
        if (q > DVD_W'(g)) begin
            mag = g;
        end else begin
            mag = q[GAIN_W-1:0];
        end
        pos = VEL_W'(mag) - VEL_W'(dz);
        if (span_bad || (mag < dz)) begin
            res = '0;
        end else if (p.neg ^ inv) begin
            res = signed'(-pos);
        end else begin
            res = signed'(pos);
        end
        return res;
    endfunction

    assign gain       = r_fast_mode ? GAIN_FAST : GAIN_SLOW;
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign div_start  = (r_state == ST_PREP);

    // In calibration the divider averages: each sample is divided by the
    // number of center samples. In run mode it scales the displacement by the
    // gain over the span on the stick's side of the center.
    always_comb begin
        if (r_calibrate_mode) begin
            x_dividend = DVD_W'(r_x_smp);
            y_dividend = DVD_W'(r_y_smp);
            x_divisor  = DVS_W'(CENTRE_SAMPLES);
            y_divisor  = DVS_W'(CENTRE_SAMPLES);
        end else begin
            x_dividend = DVD_W'(r_x_prep.d) * DVD_W'(gain);
            y_dividend = DVD_W'(r_y_prep.d) * DVD_W'(gain);
            x_divisor  = DVS_W'(r_x_prep.span[SAMPLE_BITS-1:0]);
            y_divisor  = DVS_W'(r_y_prep.span[SAMPLE_BITS-1:0]);
        end
    end

    jacs_serial_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_x_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (x_dividend),
        .i_divisor  (x_divisor),
        .o_quotient (x_quo),
        .o_done     (x_done)
    );

    jacs_serial_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_y_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (y_dividend),
        .i_divisor  (y_divisor),
        .o_quotient (y_quo),
        .o_done     (y_done)
    );

    // The first calibration sample clears the geometry, the next
    // CENTRE_SAMPLES samples build the center, and the count then stays put.
    always_comb begin
        n_sample_count = r_sample_count;
        if (r_sample_count == '0) begin
            n_sample_count = CNT_W'(1);
        end else if (r_sample_count <= CNT_LAST) begin
            n_sample_count = r_sample_count + 1'b1;
        end
        n_learning = (n_sample_count <= CNT_LAST);
        n_x_vel    = map_vel(x_quo, r_x_prep, r_invert_x, gain, r_dead_zone);
        n_y_vel    = r_y_enable ? map_vel(y_quo, r_y_prep, r_invert_y, gain, r_dead_zone)
                                : '0;
    end

    // Configuration writes. Indexes outside the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calibrate_mode <= 1'b0;
            r_fast_mode      <= 1'b1;
            r_dead_zone      <= DEAD_ZONE_RESET;
            r_invert_x       <= 1'b1;
            r_invert_y       <= 1'b0;
            r_y_enable       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CALIBRATE_MODE: r_calibrate_mode <= i_cfg_data[0];
                CFG_FAST_MODE:      r_fast_mode      <= i_cfg_data[0];
                CFG_DEAD_ZONE:      r_dead_zone      <= i_cfg_data[DZ_W-1:0];
                CFG_INVERT_X:       r_invert_x       <= i_cfg_data[0];
                CFG_INVERT_Y:       r_invert_y       <= i_cfg_data[0];
                CFG_Y_ENABLE:       r_y_enable       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer, learned geometry and output register. A finished result is
    // held in the output register while the next request is already taken in;
    // only the final step waits for the output register to free up. In that
    // final step the output register is always reloaded, so the plain release
    // of a taken result applies only in the other states.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_sample_count <= '0;
            r_x_low_limit  <= '0;
            r_x_high_limit <= '1;
            r_y_low_limit  <= '0;
            r_y_high_limit <= '1;
            r_x_centre     <= CENTRE_RST;
            r_y_centre     <= CENTRE_RST;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_x_smp  <= i_x_sample;
                        r_y_smp  <= i_y_sample;
                        r_x_prep <= prep_axis(i_x_sample, r_x_low_limit,
                                              r_x_high_limit, r_x_centre);
                        r_y_prep <= prep_axis(i_y_sample, r_y_low_limit,
                                              r_y_high_limit, r_y_centre);
                        r_state  <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (x_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        if (r_calibrate_mode) begin
                            r_x_vel        <= '0;
                            r_y_vel        <= '0;
                            r_learning     <= n_learning;
                            r_sample_count <= n_sample_count;
                            if (r_sample_count == '0) begin
                                r_x_low_limit  <= MID_SCALE;
                                r_x_high_limit <= MID_SCALE;
                                r_y_low_limit  <= MID_SCALE;
                                r_y_high_limit <= MID_SCALE;
                                r_x_centre     <= '0;
                                r_y_centre     <= '0;
                            end else if (r_sample_count <= CNT_LAST) begin
                                // The low bits of the quotient are sample / CENTRE_SAMPLES.
                                r_x_centre <= r_x_centre + x_quo[SAMPLE_BITS-1:0];
                                r_y_centre <= r_y_centre + y_quo[SAMPLE_BITS-1:0];
                            end else begin
                                if (r_x_smp < r_x_low_limit) begin
                                    r_x_low_limit <= r_x_smp;
                                end
                                if (r_x_smp > r_x_high_limit) begin
                                    r_x_high_limit <= r_x_smp;
                                end
                                if (r_y_smp < r_y_low_limit) begin
                                    r_y_low_limit <= r_y_smp;
                                end
                                if (r_y_smp > r_y_high_limit) begin
                                    r_y_high_limit <= r_y_smp;
                                end
                            end
                        end else begin
                            r_x_vel    <= n_x_vel;
                            r_y_vel    <= n_y_vel;
                            r_learning <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_x_velocity      = r_x_vel;
    assign o_y_velocity      = r_y_vel;
    assign o_centre_learning = r_learning;

    `JACS_ASSERT_NXT(a_accept_blocks, i_clk, i_rst_n, accept, o_in_stall, "request taken while busy")
    `JACS_ASSERT_IMP(a_div_lockstep, i_clk, i_rst_n, 1'b1, x_done == y_done, "dividers out of step")
    `JACS_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, x_done, r_state == ST_DIV, "divider done outside wait")
    `JACS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_sample_count <= CNT_W'(CENTRE_SAMPLES + 1), "sample count overrun")
    `JACS_ASSERT_IMP(a_learning_quiet, i_clk, i_rst_n, o_out_valid && o_centre_learning, (o_x_velocity == '0) && (o_y_velocity == '0), "velocity while learning")

endmodule
